[rtl/ffv_pkg.sv]
// Shared types, constants and character-class functions of the field format validator.
package ffv_pkg;

    localparam int NumTmpl    = 11;
    localparam int TmplMaxLen = 19;
    localparam int PosW       = 5;
    localparam logic [PosW-1:0] PosMax = 5'd31;
    localparam int QueueDepth = 4;

    typedef enum logic [2:0] {
        DT_DATETIME = 3'd0,
        DT_DATE     = 3'd1,
        DT_TIME     = 3'd2,
        DT_INTEGER  = 3'd3,
        DT_DECIMAL  = 3'd4,
        DT_STRING   = 3'd5,
        DT_EMPTY    = 3'd6
    } data_type_t;

    localparam data_type_t DataTypeReset = DT_STRING;

    typedef enum logic [2:0] {
        IN_START,
        IN_NEG,
        IN_DIG,
        IN_ZERO,
        IN_DEAD
    } int_st_t;

    typedef enum logic [3:0] {
        DC_START,
        DC_NEG,
        DC_P1,
        DC_N1,
        DC_AD,
        DC_AP,
        DC_AF,
        DC_Z,
        DC_DEAD
    } dec_st_t;

    typedef struct packed {
        logic value_ok;
        logic column_end;
    } ffv_rec_t;

    // Character classes used inside the positional templates.
    localparam logic [7:0] ClsDigit     = "d";
    localparam logic [7:0] ClsMonTens   = "M";
    localparam logic [7:0] ClsMonUnits  = "m";
    localparam logic [7:0] ClsDayTens   = "D";
    localparam logic [7:0] ClsDayUnits  = "e";
    localparam logic [7:0] ClsHourTens  = "H";
    localparam logic [7:0] ClsHourUnits = "h";
    localparam logic [7:0] ClsSixty     = "S";

    localparam logic [7:0] ChZero  = "0";
    localparam logic [7:0] ChOne   = "1";
    localparam logic [7:0] ChTwo   = "2";
    localparam logic [7:0] ChThree = "3";
    localparam logic [7:0] ChFive  = "5";
    localparam logic [7:0] ChNine  = "9";
    localparam logic [7:0] ChMinus = "-";
    localparam logic [7:0] ChDot   = ".";

    // Templates are right-aligned in the vector; the last character sits in the low byte.
    localparam logic [TmplMaxLen*8-1:0] TmplText [NumTmpl] = '{
        "dddd", "dddd-Mm", "ddddMmDe", "dddd-Mm-De",
        "HhSd", "Hh:Sd", "HhSdSd", "Hh:Sd:Sd",
        "ddddMmDeTHhSdSd", "dddd-Mm-DeTHh:Sd", "dddd-Mm-DeTHh:Sd:Sd"
    };

    localparam logic [PosW-1:0] TmplLen [NumTmpl] = '{
        5'd4, 5'd7, 5'd8, 5'd10, 5'd4, 5'd5, 5'd6, 5'd8, 5'd15, 5'd16, 5'd19
    };

    localparam logic [NumTmpl-1:0] GroupDatetime = 11'h700;
    localparam logic [NumTmpl-1:0] GroupDate     = 11'h00F;
    localparam logic [NumTmpl-1:0] GroupTime     = 11'h0F0;

    function automatic logic in_rng(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic class_ok(logic [7:0] code, logic [7:0] c, logic [7:0] prev);
        logic ok;
        unique case (code)
            ClsDigit:     ok = in_rng(c, ChZero, ChNine);
            ClsMonTens:   ok = in_rng(c, ChZero, ChOne);
            ClsMonUnits:  ok = (prev == ChZero) ? in_rng(c, ChOne, ChNine)
                                                : in_rng(c, ChZero, ChTwo);
            ClsDayTens:   ok = in_rng(c, ChZero, ChThree);
            ClsDayUnits:
            begin
                if (prev == ChZero)
                begin
                    ok = in_rng(c, ChOne, ChNine);
                end
                else if (prev == ChThree)
                begin
                    ok = in_rng(c, ChZero, ChOne);
                end
                else
                begin
                    ok = in_rng(c, ChZero, ChNine);
                end
            end
            ClsHourTens:  ok = in_rng(c, ChZero, ChTwo);
            ClsHourUnits: ok = (prev == ChTwo) ? in_rng(c, ChZero, ChThree)
                                               : in_rng(c, ChZero, ChNine);
            ClsSixty:     ok = in_rng(c, ChZero, ChFive);
            default:      ok = (c == code);
        endcase
        return ok;
    endfunction

    function automatic int_st_t int_next(int_st_t s, logic [7:0] c);
        int_st_t n;
        unique case (s)
            IN_START:
            begin
                if (c == ChMinus)
                begin
                    n = IN_NEG;
                end
                else if (c == ChZero)
                begin
                    n = IN_ZERO;
                end
                else
                begin
                    n = in_rng(c, ChOne, ChNine) ? IN_DIG : IN_DEAD;
                end
            end
            IN_NEG:  n = in_rng(c, ChOne, ChNine) ? IN_DIG : IN_DEAD;
            IN_DIG:  n = in_rng(c, ChZero, ChNine) ? IN_DIG : IN_DEAD;
            default: n = IN_DEAD;
        endcase
        return n;
    endfunction

    function automatic dec_st_t dec_next(dec_st_t s, logic [7:0] c);
        dec_st_t n;
        unique case (s)
            DC_START:
            begin
                if (c == ChMinus)
                begin
                    n = DC_NEG;
                end
                else if (c == ChZero)
                begin
                    n = DC_Z;
                end
                else
                begin
                    n = in_rng(c, ChOne, ChNine) ? DC_P1 : DC_DEAD;
                end
            end
            DC_NEG: n = in_rng(c, ChOne, ChNine) ? DC_N1 : DC_DEAD;
            DC_P1, DC_N1, DC_AD:
            begin
                if (in_rng(c, ChZero, ChNine))
                begin
                    n = DC_AD;
                end
                else
                begin
                    n = (c == ChDot) ? DC_AP : DC_DEAD;
                end
            end
            DC_AP, DC_AF: n = in_rng(c, ChZero, ChNine) ? DC_AF : DC_DEAD;
            DC_Z:         n = (c == ChDot) ? DC_AP : DC_DEAD;
            default:      n = DC_DEAD;
        endcase
        return n;
    endfunction

endpackage

[rtl/ffv_if.sv]
// Valid/ready channel interfaces for the input bytes and the per-value results.
interface ffv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       value_end;
    logic       column_end;

    modport source (output valid, output ch, output has_char, output value_end,
                    output column_end, input ready);
    modport sink (input valid, input ch, input has_char, input value_end,
                  input column_end, output ready);
endinterface

interface ffv_out_if;
    logic valid;
    logic ready;
    logic value_ok;
    logic column_ok;
    logic column_done;

    modport source (output valid, output value_ok, output column_ok, output column_done,
                    input ready);
    modport sink (input valid, input value_ok, input column_ok, input column_done,
                  output ready);
endinterface

[rtl/ffv_front.sv]
// Front end: takes byte beats, runs the template and number recognizers, classifies each value.
module ffv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_wdata,
    ffv_in_if.sink            req,
    input  logic              q_full,
    output logic              q_push,
    output ffv_pkg::ffv_rec_t q_data
);

    ffv_pkg::data_type_t                   data_type_reg;
    logic [ffv_pkg::PosW-1:0]              pos_reg, pos_next;
    logic [ffv_pkg::NumTmpl-1:0]           alive_reg, alive_next;
    ffv_pkg::int_st_t                      int_reg, int_next;
    ffv_pkg::dec_st_t                      dec_reg, dec_next;
    logic [7:0]                            prev_reg, prev_next;
    logic                                  accept;
    logic                                  match;
    logic [ffv_pkg::NumTmpl-1:0]           len_hit;
    logic [ffv_pkg::NumTmpl-1:0]           step_ok;
    logic [ffv_pkg::PosW-1:0]              byte_idx [ffv_pkg::NumTmpl];

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        for (int i = 0; i < ffv_pkg::NumTmpl; i++)
        begin
            byte_idx[i] = ffv_pkg::TmplLen[i] - pos_reg - 5'd1;
            step_ok[i]  = (pos_reg < ffv_pkg::TmplLen[i]) &&
                          ffv_pkg::class_ok(ffv_pkg::TmplText[i][{byte_idx[i], 3'b000} +: 8],
                                            req.ch, prev_reg);
        end
        if (req.has_char)
        begin
            alive_next = alive_reg & step_ok;
            int_next   = ffv_pkg::int_next(int_reg, req.ch);
            dec_next   = ffv_pkg::dec_next(dec_reg, req.ch);
            pos_next   = (pos_reg == ffv_pkg::PosMax) ? pos_reg : pos_reg + 5'd1;
            prev_next  = req.ch;
        end
        else
        begin
            alive_next = alive_reg;
            int_next   = int_reg;
            dec_next   = dec_reg;
            pos_next   = pos_reg;
            prev_next  = prev_reg;
        end
        for (int i = 0; i < ffv_pkg::NumTmpl; i++)
        begin
            len_hit[i] = (pos_next == ffv_pkg::TmplLen[i]);
        end
        unique case (data_type_reg)
            ffv_pkg::DT_DATETIME: match = |(alive_next & len_hit & ffv_pkg::GroupDatetime);
            ffv_pkg::DT_DATE:     match = |(alive_next & len_hit & ffv_pkg::GroupDate);
            ffv_pkg::DT_TIME:     match = |(alive_next & len_hit & ffv_pkg::GroupTime);
            ffv_pkg::DT_INTEGER:  match = (int_next == ffv_pkg::IN_DIG) ||
                                          (int_next == ffv_pkg::IN_ZERO);
            ffv_pkg::DT_DECIMAL:  match = (dec_next == ffv_pkg::DC_P1) ||
                                          (dec_next == ffv_pkg::DC_AD) ||
                                          (dec_next == ffv_pkg::DC_AF) ||
                                          (dec_next == ffv_pkg::DC_Z);
            ffv_pkg::DT_STRING:   match = 1'b1;
            ffv_pkg::DT_EMPTY:    match = (pos_next == '0);
            default:              match = 1'b0;
        endcase
    end

    assign q_push            = accept && req.value_end;
    assign q_data.value_ok   = match;
    assign q_data.column_end = req.column_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_type_reg <= ffv_pkg::DataTypeReset;
        end
        else if (cfg_we)
        begin
            data_type_reg <= ffv_pkg::data_type_t'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            alive_reg <= '1;
            int_reg   <= ffv_pkg::IN_START;
            dec_reg   <= ffv_pkg::DC_START;
            prev_reg  <= '0;
        end
        else if (accept)
        begin
            if (req.value_end)
            begin
                pos_reg   <= '0;
                alive_reg <= '1;
                int_reg   <= ffv_pkg::IN_START;
                dec_reg   <= ffv_pkg::DC_START;
                prev_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                alive_reg <= alive_next;
                int_reg   <= int_next;
                dec_reg   <= dec_next;
                prev_reg  <= prev_next;
            end
        end
    end

endmodule

[rtl/ffv_fifo.sv]
// Short queue of classified values between the front and the back end.
module ffv_fifo #(
    parameter int Depth = ffv_pkg::QueueDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffv_pkg::ffv_rec_t push_data,
    output logic              full,
    input  logic              pop,
    output ffv_pkg::ffv_rec_t pop_data,
    output logic              empty
);

    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

    ffv_pkg::ffv_rec_t mem [Depth];
    logic [AddrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastAddr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastAddr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/ffv_back.sv]
// Back end: folds value flags into the column result and holds the output beat.
module ffv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ffv_pkg::ffv_rec_t q_data,
    output logic              q_pop,
    ffv_out_if.source         rsp
);

    logic all_ok_reg;
    logic valid_reg;
    logic value_ok_reg;
    logic column_ok_reg;
    logic column_done_reg;
    logic all_ok_now;

    assign q_pop      = !q_empty && (!valid_reg || rsp.ready);
    assign all_ok_now = all_ok_reg && q_data.value_ok;

    assign rsp.valid       = valid_reg;
    assign rsp.value_ok    = value_ok_reg;
    assign rsp.column_ok   = column_ok_reg;
    assign rsp.column_done = column_done_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            value_ok_reg    <= q_data.value_ok;
            column_ok_reg   <= q_data.column_end && all_ok_now;
            column_done_reg <= q_data.column_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            all_ok_reg <= 1'b1;
        end
        else
        begin
            if (q_pop)
            begin
                valid_reg  <= 1'b1;
                all_ok_reg <= q_data.column_end ? 1'b1 : all_ok_now;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/field_format_validator_unit.sv]
// Top level of the field format validator: front end, value queue and back end.
// The block takes one byte beat per cycle and never stalls the input while the queue has room;
// the result for a value passes through the queue and then the back end's output register, and the
// queue of QueueDepth classified values absorbs that many results while the output is stalled.
module field_format_validator_unit #(
    parameter int QueueDepth = ffv_pkg::QueueDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    ffv_in_if.sink     req,
    ffv_out_if.source  rsp
);

    ffv_pkg::ffv_rec_t push_data;
    ffv_pkg::ffv_rec_t pop_data;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    ffv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .q_full    (full),
        .q_push    (push),
        .q_data    (push_data)
    );

    ffv_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ffv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (empty),
        .q_data  (pop_data),
        .q_pop   (pop),
        .rsp     (rsp)
    );

endmodule

[rtl/ffv_checker.sv]
// Port-level checks of the field format validator, bound to the top level.
module ffv_checker (
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_value_ok,
    input logic rsp_column_ok,
    input logic rsp_column_done
);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_ok) &&
        $stable(rsp_column_ok) && $stable(rsp_column_done))
        else $error("Result beat changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_column_ok |-> rsp_column_done)
        else $error("Column flag set on a beat that does not close the column.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_column_ok |-> rsp_value_ok)
        else $error("Column passed although its last value failed.");

endmodule

bind field_format_validator_unit ffv_checker u_ffv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_value_ok    (rsp.value_ok),
    .rsp_column_ok   (rsp.column_ok),
    .rsp_column_done (rsp.column_done)
);

[dv/ffv_value_checker.sv]
// Checker that watches the byte and result channels, predicts each value verdict and compares it.
module ffv_value_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    ffv_in_if          req,
    ffv_out_if         rsp,
    output int         errors,
    output int         pending
);

    localparam int NumForms = 11;
    localparam int ReportLimit = 10;
    localparam logic [4:0] SpanMax = 5'd31;

    localparam logic [NumForms-1:0] MaskDatetime = 11'h700;
    localparam logic [NumForms-1:0] MaskDate     = 11'h00F;
    localparam logic [NumForms-1:0] MaskTime     = 11'h0F0;

    localparam logic [7:0] FmDigit   = "d";
    localparam logic [7:0] FmMonthHi = "M";
    localparam logic [7:0] FmMonthLo = "m";
    localparam logic [7:0] FmDayHi   = "D";
    localparam logic [7:0] FmDayLo   = "e";
    localparam logic [7:0] FmHourHi  = "H";
    localparam logic [7:0] FmHourLo  = "h";
    localparam logic [7:0] FmSixty   = "S";

    typedef struct packed {
        logic value_ok;
        logic column_ok;
        logic column_done;
    } verdict_t;

    string forms [NumForms] = '{
        "dddd", "dddd-Mm", "ddddMmDe", "dddd-Mm-De",
        "HhSd", "Hh:Sd", "HhSdSd", "Hh:Sd:Sd",
        "ddddMmDeTHhSdSd", "dddd-Mm-DeTHh:Sd", "dddd-Mm-DeTHh:Sd:Sd"
    };

    verdict_t            verdicts_due[$];
    ffv_pkg::data_type_t col_type    = ffv_pkg::DT_STRING;
    logic [4:0]          span        = '0;
    logic [NumForms-1:0] live_forms  = '1;
    ffv_pkg::int_st_t    int_pos     = ffv_pkg::IN_START;
    ffv_pkg::dec_st_t    dec_pos     = ffv_pkg::DC_START;
    logic [7:0]          last_ch     = '0;
    logic                column_good = 1'b1;
    logic                column_seen = 1'b0;
    int                  mismatches  = 0;

    initial
    begin
        errors = 0;
        pending = 0;
    end

    function automatic logic between(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic logic form_char_ok(logic [7:0] code, logic [7:0] c, logic [7:0] p);
        case (code)
            FmDigit:   return between(c, "0", "9");
            FmMonthHi: return between(c, "0", "1");
            FmMonthLo: return (p == "0") ? between(c, "1", "9") : between(c, "0", "2");
            FmDayHi:   return between(c, "0", "3");
            FmDayLo:
            begin
                if (p == "0")
                begin
                    return between(c, "1", "9");
                end
                if (p == "3")
                begin
                    return between(c, "0", "1");
                end
                return between(c, "0", "9");
            end
            FmHourHi:  return between(c, "0", "2");
            FmHourLo:  return (p == "2") ? between(c, "0", "3") : between(c, "0", "9");
            FmSixty:   return between(c, "0", "5");
            default:   return c == code;
        endcase
    endfunction

    function automatic ffv_pkg::int_st_t step_integer(ffv_pkg::int_st_t s, logic [7:0] c);
        logic lead;
        lead = between(c, "1", "9");
        if (s == ffv_pkg::IN_START)
        begin
            if (c == "-")
            begin
                return ffv_pkg::IN_NEG;
            end
            if (c == "0")
            begin
                return ffv_pkg::IN_ZERO;
            end
            return lead ? ffv_pkg::IN_DIG : ffv_pkg::IN_DEAD;
        end
        if (s == ffv_pkg::IN_NEG)
        begin
            return lead ? ffv_pkg::IN_DIG : ffv_pkg::IN_DEAD;
        end
        if (s == ffv_pkg::IN_DIG && between(c, "0", "9"))
        begin
            return ffv_pkg::IN_DIG;
        end
        return ffv_pkg::IN_DEAD;
    endfunction

    function automatic ffv_pkg::dec_st_t step_decimal(ffv_pkg::dec_st_t s, logic [7:0] c);
        logic digit;
        digit = between(c, "0", "9");
        case (s)
            ffv_pkg::DC_START:
            begin
                if (c == "-")
                begin
                    return ffv_pkg::DC_NEG;
                end
                if (c == "0")
                begin
                    return ffv_pkg::DC_Z;
                end
                return between(c, "1", "9") ? ffv_pkg::DC_P1 : ffv_pkg::DC_DEAD;
            end
            ffv_pkg::DC_NEG:
            begin
                return between(c, "1", "9") ? ffv_pkg::DC_N1 : ffv_pkg::DC_DEAD;
            end
            ffv_pkg::DC_P1, ffv_pkg::DC_N1, ffv_pkg::DC_AD:
            begin
                if (digit)
                begin
                    return ffv_pkg::DC_AD;
                end
                return (c == ".") ? ffv_pkg::DC_AP : ffv_pkg::DC_DEAD;
            end
            ffv_pkg::DC_AP, ffv_pkg::DC_AF:
            begin
                return digit ? ffv_pkg::DC_AF : ffv_pkg::DC_DEAD;
            end
            ffv_pkg::DC_Z:
            begin
                return (c == ".") ? ffv_pkg::DC_AP : ffv_pkg::DC_DEAD;
            end
            default: return ffv_pkg::DC_DEAD;
        endcase
    endfunction

    function automatic logic value_fits();
        logic [NumForms-1:0] at_end;
        for (int i = 0; i < NumForms; i++)
        begin
            at_end[i] = (span == forms[i].len());
        end
        case (col_type)
            ffv_pkg::DT_DATETIME: return |(live_forms & at_end & MaskDatetime);
            ffv_pkg::DT_DATE:     return |(live_forms & at_end & MaskDate);
            ffv_pkg::DT_TIME:     return |(live_forms & at_end & MaskTime);
            ffv_pkg::DT_INTEGER:
            begin
                return int_pos == ffv_pkg::IN_DIG || int_pos == ffv_pkg::IN_ZERO;
            end
            ffv_pkg::DT_DECIMAL:
            begin
                return dec_pos == ffv_pkg::DC_P1 || dec_pos == ffv_pkg::DC_AD ||
                       dec_pos == ffv_pkg::DC_AF || dec_pos == ffv_pkg::DC_Z;
            end
            ffv_pkg::DT_STRING:   return 1'b1;
            ffv_pkg::DT_EMPTY:    return span == 0;
            default:              return 1'b0;
        endcase
    endfunction

    function automatic void restart_value();
        span = '0;
        live_forms = '1;
        int_pos = ffv_pkg::IN_START;
        dec_pos = ffv_pkg::DC_START;
        last_ch = '0;
    endfunction

    function automatic void take_beat(logic [7:0] c, logic has, logic ends, logic closes);
        verdict_t v;
        if (has)
        begin
            for (int i = 0; i < NumForms; i++)
            begin
                if (live_forms[i] && !(span < forms[i].len() &&
                                       form_char_ok(forms[i].getc(span), c, last_ch)))
                begin
                    live_forms[i] = 1'b0;
                end
            end
            int_pos = step_integer(int_pos, c);
            dec_pos = step_decimal(dec_pos, c);
            if (span != SpanMax)
            begin
                span = span + 5'd1;
            end
            last_ch = c;
        end
        if (!ends)
        begin
            return;
        end
        v.value_ok = value_fits();
        column_good = column_good & v.value_ok;
        column_seen = 1'b1;
        v.column_ok = closes & column_good & column_seen;
        v.column_done = closes;
        verdicts_due.insert(verdicts_due.size(), v);
        if (closes)
        begin
            column_good = 1'b1;
            column_seen = 1'b0;
        end
        restart_value();
    endfunction

    function automatic void compare_beat(verdict_t got);
        verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= ReportLimit)
            begin
                $display("ffv_value_checker: unexpected beat ok/col/done %0b/%0b/%0b",
                         got.value_ok, got.column_ok, got.column_done);
            end
            return;
        end
        want = verdicts_due.pop_front();
        if (got.value_ok != want.value_ok || got.column_ok != want.column_ok ||
            got.column_done != want.column_done)
        begin
            mismatches++;
            if (mismatches <= ReportLimit)
            begin
                $display("ffv_value_checker: expected ok/col/done %0b/%0b/%0b, got %0b/%0b/%0b",
                         want.value_ok, want.column_ok, want.column_done,
                         got.value_ok, got.column_ok, got.column_done);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdicts_due.delete();
            col_type = ffv_pkg::DT_STRING;
            column_good = 1'b1;
            column_seen = 1'b0;
            restart_value();
            pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                take_beat(req.ch, req.has_char, req.value_end, req.column_end);
            end
            if (rsp.valid && rsp.ready)
            begin
                compare_beat(verdict_t'({rsp.value_ok, rsp.column_ok, rsp.column_done}));
            end
            if (cfg_we)
            begin
                col_type = ffv_pkg::data_type_t'(cfg_wdata);
            end
            pending <= verdicts_due.size();
            errors <= mismatches;
        end
    end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, byte stimulus, result back-pressure and the final verdict.
module tb_top;

    localparam logic [2:0] TypeUnused = 3'd7;
    localparam logic [7:0] Ascii0 = "0";
    localparam int ItemTarget = 1300;
    localparam int SettleCycles = 8;
    localparam int HoldCycles = 300;
    localparam int CycleLimit = 200000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_wdata;
    int         errors;
    int         due_count;
    int         cycles = 0;
    int         items = 0;
    int         tx_idle_pct = 35;
    int         rx_idle_pct = 35;
    bit         hold_rx = 1'b0;
    logic [7:0] text_q[$];

    ffv_in_if  byte_ch ();
    ffv_out_if verdict_ch ();

    field_format_validator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (byte_ch),
        .rsp       (verdict_ch)
    );

    ffv_value_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (byte_ch),
        .rsp       (verdict_ch),
        .errors    (errors),
        .pending   (due_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        verdict_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                verdict_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_rx = 1'b0;
            end
            else
            begin
                verdict_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_beat(logic [7:0] c, logic has, logic ends, logic closes);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.ch <= c;
        byte_ch.has_char <= has;
        byte_ch.value_end <= ends;
        byte_ch.column_end <= closes;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        if (has || ends)
        begin
            items++;
        end
    endtask

    task automatic send_value(logic closes);
        int last;
        last = text_q.size() - 1;
        if (text_q.size() == 0)
        begin
            send_beat(8'($urandom), 1'b0, 1'b1, closes);
            return;
        end
        for (int k = 0; k <= last; k++)
        begin
            if ($urandom_range(99) < 4)
            begin
                send_beat(8'($urandom), 1'b0, 1'b0, 1'($urandom_range(1)));
            end
            send_beat(text_q[k], 1'b1, k == last,
                      (k == last) ? closes : ($urandom_range(99) < 3));
        end
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_type(logic [2:0] t);
        cfg_wdata <= t;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void put_str(string s);
        for (int k = 0; k < s.len(); k++)
        begin
            text_q.insert(text_q.size(), s.getc(k));
        end
    endfunction

    function automatic void put_num(int v, int w);
        int base;
        base = text_q.size();
        repeat (w)
        begin
            text_q.insert(base, 8'(Ascii0 + v % 10));
            v = v / 10;
        end
    endfunction

    function automatic void put_digit(int lo);
        text_q.insert(text_q.size(), 8'(Ascii0 + $urandom_range(9, lo)));
    endfunction

    function automatic int fld(int lo, int hi, int wide);
        return ($urandom_range(99) < 85) ? int'($urandom_range(hi, lo))
                                         : int'($urandom_range(wide));
    endfunction

    function automatic void put_ymd(bit dashed);
        put_num($urandom_range(9999), 4);
        if (dashed)
        begin
            put_str("-");
        end
        put_num(fld(1, 12, 19), 2);
        if (dashed)
        begin
            put_str("-");
        end
        put_num(fld(1, 31, 39), 2);
    endfunction

    function automatic void put_hm(bit colons, bit secs);
        put_num(fld(0, 23, 29), 2);
        if (colons)
        begin
            put_str(":");
        end
        put_num(fld(0, 59, 69), 2);
        if (secs)
        begin
            if (colons)
            begin
                put_str(":");
            end
            put_num(fld(0, 59, 69), 2);
        end
    endfunction

    function automatic void put_noise();
        int len;
        len = ($urandom_range(9) == 0) ? int'($urandom_range(40, 20)) : int'($urandom_range(8));
        repeat (len)
        begin
            text_q.insert(text_q.size(), 8'($urandom));
        end
    endfunction

    function automatic void put_shape(logic [2:0] t);
        int form;
        case (t)
            ffv_pkg::DT_DATETIME:
            begin
                form = $urandom_range(2);
                put_ymd(form != 0);
                put_str("T");
                put_hm(form != 0, form != 1);
            end
            ffv_pkg::DT_DATE:
            begin
                form = $urandom_range(3);
                if (form >= 2)
                begin
                    put_ymd(form == 3);
                end
                else
                begin
                    put_num($urandom_range(9999), 4);
                    if (form == 1)
                    begin
                        put_str("-");
                        put_num(fld(1, 12, 19), 2);
                    end
                end
            end
            ffv_pkg::DT_TIME:
            begin
                form = $urandom_range(3);
                put_hm(form[0], form[1]);
            end
            ffv_pkg::DT_INTEGER:
            begin
                form = $urandom_range(4);
                if (form == 0)
                begin
                    put_str("0");
                end
                else if (form == 1)
                begin
                    put_str("-0");
                end
                else if (form == 2)
                begin
                    put_str("0");
                    put_num($urandom_range(999), 3);
                end
                else
                begin
                    if ($urandom_range(1))
                    begin
                        put_str("-");
                    end
                    put_digit(1);
                    repeat ($urandom_range(9)) put_digit(0);
                end
            end
            ffv_pkg::DT_DECIMAL:
            begin
                if ($urandom_range(2) == 0)
                begin
                    put_str("-");
                end
                if ($urandom_range(2) == 0)
                begin
                    put_str("0");
                end
                else
                begin
                    put_digit(1);
                    repeat ($urandom_range(4)) put_digit(0);
                end
                if ($urandom_range(1))
                begin
                    put_str(".");
                end
                repeat ($urandom_range(3)) put_digit(0);
            end
            ffv_pkg::DT_STRING:
            begin
                put_noise();
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void mutate();
        int at;
        if (text_q.size() == 0)
        begin
            put_digit(0);
            return;
        end
        at = $urandom_range(text_q.size() - 1);
        case ($urandom_range(3))
            0:       text_q[at] = 8'($urandom);
            1:       text_q[at] = 8'(Ascii0 + $urandom_range(9));
            2:       put_digit(0);
            default: void'(text_q.pop_back());
        endcase
    endfunction

    function automatic void build_cell(logic [2:0] t);
        int r;
        text_q.delete();
        r = $urandom_range(99);
        if (r >= 85)
        begin
            put_noise();
            return;
        end
        if (r >= 70 || t == TypeUnused)
        begin
            t = 3'($urandom_range(6));
        end
        put_shape(t);
        if (t <= ffv_pkg::DT_DECIMAL && $urandom_range(99) < 20)
        begin
            mutate();
        end
    endfunction

    task automatic send_text(string s, logic closes);
        text_q.delete();
        put_str(s);
        send_value(closes);
    endtask

    initial
    begin
        logic [2:0] kind;
        int ncol;
        int nval;
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.ch = '0;
        byte_ch.has_char = 1'b0;
        byte_ch.value_end = 1'b0;
        byte_ch.column_end = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The reset type is string: anything passes, the empty value too.
        send_text("", 1'b0);
        send_beat(8'h5A, 1'b0, 1'b0, 1'b1);
        text_q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        send_value(1'b1);

        drain();
        set_type(ffv_pkg::DT_EMPTY);
        send_text("", 1'b0);
        send_text("a", 1'b1);
        send_text("", 1'b1);

        drain();
        set_type(ffv_pkg::DT_INTEGER);
        send_text("0", 1'b0);
        send_text("-0", 1'b0);
        send_text("-12", 1'b0);
        send_beat("7", 1'b1, 1'b0, 1'b1);
        send_text("5", 1'b1);

        drain();
        set_type(ffv_pkg::DT_DECIMAL);
        send_text("-5", 1'b0);
        send_text("15", 1'b0);
        send_text("0.5", 1'b0);
        send_text("-1.5", 1'b0);
        send_text("1.", 1'b0);
        send_text("7", 1'b1);

        drain();
        set_type(ffv_pkg::DT_DATE);
        send_text("2024", 1'b0);
        send_text("1999-12", 1'b0);
        send_text("20240131", 1'b0);
        send_text("2024-13", 1'b0);
        send_text("0000-01-30", 1'b1);

        drain();
        set_type(ffv_pkg::DT_TIME);
        send_text("2359", 1'b0);
        send_text("23:59", 1'b0);
        send_text("235959", 1'b0);
        send_text("24:00", 1'b0);
        send_text("00:00:60", 1'b1);

        drain();
        set_type(ffv_pkg::DT_DATETIME);
        send_text("20241231T235959", 1'b0);
        send_text("2024-01-01T00:00", 1'b0);
        send_text("2024-01-01t00:00:59", 1'b0);
        send_text("2024-01-01T23:59:59", 1'b1);

        drain();
        set_type(TypeUnused);
        send_text("1", 1'b1);

        // The type is switched in the middle of a value; the one at value end decides.
        drain();
        set_type(ffv_pkg::DT_INTEGER);
        send_beat("1", 1'b1, 1'b0, 1'b0);
        drain();
        set_type(ffv_pkg::DT_DATE);
        send_text("999", 1'b1);

        phase = 0;
        while (items < ItemTarget)
        begin
            drain();
            tx_idle_pct = (phase == 3) ? 0 : 35;
            rx_idle_pct = (phase == 3) ? 0 : 35;
            kind = ($urandom_range(99) < 6) ? TypeUnused : 3'($urandom_range(6));
            set_type(kind);
            if (phase == 5)
            begin
                hold_rx = 1'b1;
                tx_idle_pct = 0;
                repeat (12) send_text("", 1'b0);
            end
            ncol = (phase == 3) ? 8 : int'($urandom_range(3, 1));
            repeat (ncol)
            begin
                nval = $urandom_range(6, 1);
                for (int v = 0; v < nval; v++)
                begin
                    build_cell(kind);
                    send_value(v == nval - 1);
                end
            end
            phase++;
        end

        drain();
        if (errors == 0 && due_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
